[design/assert_macros.svh]
// Assertion helpers used by bicubic_image_resize.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, clocked on clk and disabled during reset.
`define ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication violated");

`endif

[design/bir_pkg.sv]
package bir_pkg;

  localparam int FRAC_W = 16;
  localparam int WGT_W  = 16;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [53:0]      num_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_SQ   = 7'b0000100,
    ST_CU   = 7'b0001000,
    ST_WGT  = 7'b0010000,
    ST_READ = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  localparam logic [1:0] CFG_SRC_ROWS = 2'd0;
  localparam logic [1:0] CFG_SRC_COLS = 2'd1;
  localparam logic [1:0] CFG_DST_ROWS = 2'd2;
  localparam logic [1:0] CFG_DST_COLS = 2'd3;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] TAP_M1 = 2'd0;
  localparam logic [1:0] TAP_0  = 2'd1;
  localparam logic [1:0] TAP_P1 = 2'd2;
  localparam logic [1:0] TAP_P2 = 2'd3;

  localparam num_t NUM_ONE  = 54'sh1_0000_0000_0000;
  localparam num_t NUM_HALF = 54'sh4_0000_0000;

  // Keys kernel weight for one tap, from the fraction and its square and cube.
  function automatic wgt_t keys_weight(input logic [1:0] tap,
                                       input logic [FRAC_W-1:0] f,
                                       input logic [2*FRAC_W-1:0] f2,
                                       input logic [3*FRAC_W-1:0] f3);
    num_t s1;
    num_t s2;
    num_t s3;
    num_t num;
    num_t rnd;
    s1 = num_t'(f) <<< 32;
    s2 = num_t'(f2) <<< 16;
    s3 = num_t'(f3);
    case (tap)
      TAP_M1:  num = -s3 + (s2 <<< 1) - s1;
      TAP_0:   num = 3 * s3 - 5 * s2 + (NUM_ONE <<< 1);
      TAP_P1:  num = -3 * s3 + 4 * s2 + s1;
      default: num = s3 - s2;
    endcase
    rnd = (num + NUM_HALF) >>> 35;
    return rnd[WGT_W-1:0];
  endfunction

endpackage

[design/bicubic_image_resize.sv]
// Bicubic resizer with the Keys kernel (a = -0.5). A write request (cmd 0) stores one 8-bit
// source pixel in a synchronous memory if it lies inside the configured source size. A compute
// request (cmd 1) runs an NW-bit bit-serial coordinate divider, where NW = 28 + clog2(max source
// size + 1) (37 with the default parameters), then the square, cube and weight steps for the
// weight polynomials, then the sixteen neighbourhood reads through the one memory read port and
// the multiply-accumulate pipeline behind it. A finished result waits in the output
// register while the next request is taken. The source memory is not cleared after reset;
// every pixel inside the configured source size must be written before it is used.
`include "assert_macros.svh"

module bicubic_image_resize
  import bir_pkg::*;
#(
  parameter int SRC_MAX_ROWS = 256,
  parameter int SRC_MAX_COLS = 256,
  parameter int DST_MAX_DIM  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        cmd,
  input  logic [11:0] row,
  input  logic [11:0] col,
  input  logic [7:0]  pixel,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic [7:0]  value
);

  localparam int SRW   = $clog2(SRC_MAX_ROWS + 1);
  localparam int SCW   = $clog2(SRC_MAX_COLS + 1);
  localparam int SW    = (SRW > SCW) ? SRW : SCW;
  localparam int DW    = $clog2(DST_MAX_DIM + 1);
  localparam int NW    = 12 + SW + FRAC_W;
  localparam int BW    = NW - FRAC_W;
  localparam int CW    = $clog2(NW + 1);
  localparam int RAW   = $clog2(SRC_MAX_ROWS);
  localparam int CAW   = $clog2(SRC_MAX_COLS);
  localparam int DEPTH = SRC_MAX_ROWS * SRC_MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [8:0]  src_rows;
  logic [8:0]  src_cols;
  logic [12:0] dst_rows;
  logic [12:0] dst_cols;
  logic [SRW-1:0] sr_eff;
  logic [SCW-1:0] sc_eff;
  logic [DW-1:0]  dr_eff;
  logic [DW-1:0]  dc_eff;

  state_t state;
  logic [11:0] row_q;
  logic [11:0] col_q;
  logic [NW-1:0] qr;
  logic [NW-1:0] qc;
  logic [DW-1:0] rr;
  logic [DW-1:0] rc;
  logic [NW-1:0] qr_next;
  logic [NW-1:0] qc_next;
  logic [DW-1:0] rr_next;
  logic [DW-1:0] rc_next;
  logic [CW-1:0] div_cnt;
  logic [BW-1:0] prod_r;
  logic [BW-1:0] prod_c;
  logic [2*FRAC_W-1:0] fr2;
  logic [2*FRAC_W-1:0] fc2;
  logic [3*FRAC_W-1:0] fr3;
  logic [3*FRAC_W-1:0] fc3;
  wgt_t wr [4];
  wgt_t wc [4];
  logic [RAW-1:0] tap_r [4];
  logic [CAW-1:0] tap_c [4];
  logic [RAW-1:0] tap_r_next [4];
  logic [CAW-1:0] tap_c_next [4];
  logic [4:0] cnt;
  logic issue;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic mem_we;
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;
  logic v1;
  logic v2;
  logic v3;
  logic [3:0] idx1;
  logic [3:0] idx2;
  logic signed [24:0] p1;
  logic signed [40:0] p2;
  logic signed [43:0] acc;
  logic [7:0] value_next;
  logic req_fire;
  logic fin_load;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign fin_load  = (state == ST_FIN) && (!res_valid || res_ready);

  always_comb begin
    if (src_rows == '0) sr_eff = SRW'(1);
    else if (32'(src_rows) > SRC_MAX_ROWS) sr_eff = SRW'(SRC_MAX_ROWS);
    else sr_eff = SRW'(src_rows);
    if (src_cols == '0) sc_eff = SCW'(1);
    else if (32'(src_cols) > SRC_MAX_COLS) sc_eff = SCW'(SRC_MAX_COLS);
    else sc_eff = SCW'(src_cols);
    if (dst_rows == '0) dr_eff = DW'(1);
    else if (32'(dst_rows) > DST_MAX_DIM) dr_eff = DW'(DST_MAX_DIM);
    else dr_eff = DW'(dst_rows);
    if (dst_cols == '0) dc_eff = DW'(1);
    else if (32'(dst_cols) > DST_MAX_DIM) dc_eff = DW'(DST_MAX_DIM);
    else dc_eff = DW'(dst_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_rows <= 9'd1;
      src_cols <= 9'd1;
      dst_rows <= 13'd1;
      dst_cols <= 13'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_ROWS: src_rows <= cfg_data[8:0];
        CFG_SRC_COLS: src_cols <= cfg_data[8:0];
        CFG_DST_ROWS: dst_rows <= cfg_data;
        default:      dst_cols <= cfg_data;
      endcase
    end
  end

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] r,
                                                input logic [NW-1:0] q,
                                                input logic [DW-1:0] d);
    logic [DW:0] sh;
    logic [DW:0] diff;
    sh   = {r, q[NW-1]};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) return {diff[DW-1:0], q[NW-2:0], 1'b1};
    else return {sh[DW-1:0], q[NW-2:0], 1'b0};
  endfunction

  assign prod_r = BW'(row) * BW'(sr_eff);
  assign prod_c = BW'(col) * BW'(sc_eff);
  assign {rr_next, qr_next} = div_step(rr, qr, dr_eff);
  assign {rc_next, qc_next} = div_step(rc, qc, dc_eff);

  always_comb begin
    logic [BW:0] t;
    for (int k = 0; k < 4; k++) begin
      if (qr[NW-1:FRAC_W] == '0 && k == 0) t = '0;
      else t = {1'b0, qr[NW-1:FRAC_W]} + (BW+1)'(k) - (BW+1)'(1);
      if (t > (BW+1)'(sr_eff - SRW'(1))) tap_r_next[k] = RAW'(sr_eff - SRW'(1));
      else tap_r_next[k] = t[RAW-1:0];
      if (qc[NW-1:FRAC_W] == '0 && k == 0) t = '0;
      else t = {1'b0, qc[NW-1:FRAC_W]} + (BW+1)'(k) - (BW+1)'(1);
      if (t > (BW+1)'(sc_eff - SCW'(1))) tap_c_next[k] = CAW'(sc_eff - SCW'(1));
      else tap_c_next[k] = t[CAW-1:0];
    end
  end

  assign issue   = (state == ST_READ) && (cnt < 5'd16);
  assign rd_addr = AW'(tap_r[cnt[3:2]]) * AW'(SRC_MAX_COLS) + AW'(tap_c[cnt[1:0]]);
  assign wr_addr = AW'(row[RAW-1:0]) * AW'(SRC_MAX_COLS) + AW'(col[CAW-1:0]);
  assign mem_we  = req_fire && (cmd == CMD_WRITE) && ({1'b0, row} < 13'(sr_eff))
                   && ({1'b0, col} < 13'(sc_eff));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= pixel;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    if (acc[43]) value_next = 8'd0;
    else if (|acc[42:36]) value_next = 8'd255;
    else value_next = acc[35:28];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      div_cnt   <= '0;
      cnt       <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      res_valid <= fin_load || (res_valid && !res_ready);
      unique case (state)
        ST_IDLE: begin
          if (req_fire && cmd == CMD_COMPUTE) begin
            row_q   <= row;
            col_q   <= col;
            qr      <= {prod_r, {FRAC_W{1'b0}}};
            qc      <= {prod_c, {FRAC_W{1'b0}}};
            rr      <= '0;
            rc      <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          qr      <= qr_next;
          qc      <= qc_next;
          rr      <= rr_next;
          rc      <= rc_next;
          div_cnt <= div_cnt + CW'(1);
          if (div_cnt == CW'(NW - 1)) state <= ST_SQ;
        end
        ST_SQ: begin
          fr2   <= qr[FRAC_W-1:0] * qr[FRAC_W-1:0];
          fc2   <= qc[FRAC_W-1:0] * qc[FRAC_W-1:0];
          state <= ST_CU;
        end
        ST_CU: begin
          fr3   <= fr2 * qr[FRAC_W-1:0];
          fc3   <= fc2 * qc[FRAC_W-1:0];
          state <= ST_WGT;
        end
        ST_WGT: begin
          for (int k = 0; k < 4; k++) begin
            wr[k]    <= keys_weight(2'(k), qr[FRAC_W-1:0], fr2, fr3);
            wc[k]    <= keys_weight(2'(k), qc[FRAC_W-1:0], fc2, fc3);
            tap_r[k] <= tap_r_next[k];
            tap_c[k] <= tap_c_next[k];
          end
          cnt   <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd18) state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_load) begin
            out_row   <= row_q;
            out_col   <= col_q;
            value     <= value_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= cnt[3:0];
    idx2 <= idx1;
    p1   <= $signed({1'b0, rd_data}) * wr[idx1[3:2]];
    p2   <= p1 * wc[idx2[1:0]];
    if (state == ST_WGT) acc <= '0;
    else if (v3) acc <= acc + 44'(p2);
  end

  `ASSERT_NXT(a_compute_starts_div, req_fire && cmd == CMD_COMPUTE, state == ST_DIV)
  `ASSERT_IMP(a_div_count_bound, state == ST_DIV, div_cnt < CW'(NW))
  `ASSERT_IMP(a_acc_only_in_read, v3, state == ST_READ)
  `ASSERT_NXT(a_fin_gives_result, fin_load, res_valid && state == ST_IDLE)

endmodule
